FILE: rtl/bnnt_pkg.sv
`default_nettype none
package bnnt_pkg;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_PER   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PER   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_SQ  = 2'd2;

    localparam logic [1:0] KIND_ALIVE   = 2'd0;
    localparam logic [1:0] KIND_REMOVED = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;

    localparam int MAX_RESULTS = 16;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_COMMIT,
        ST_SORT,
        ST_EMIT,
        ST_EMIT_WAIT
    } state_t;
endpackage
`default_nettype wire

FILE: rtl/bnnt_track_mem.sv
`default_nettype none
// Track payload memory: id, x, y, area per slot. One write port, one
// registered read port.
module bnnt_track_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4,
    parameter int CW    = 16
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wid,
    input  wire logic [CW-1:0] wx,
    input  wire logic [CW-1:0] wy,
    input  wire logic [15:0]   warea,
    input  wire logic [AW-1:0] raddr,
    output logic      [31:0]   rid,
    output logic      [CW-1:0] rx,
    output logic      [CW-1:0] ry,
    output logic      [15:0]   rarea
);
    logic [32+2*CW+16-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wid, wx, wy, warea};
        end
        {rid, rx, ry, rarea} <= mem[raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/blob_nearest_neighbor_tracker_top.sv
`default_nettype none
// Blob item: one memory read per slot, then a commit; a discarded blob is dropped
// without a scan. Frame end: a sort pass reads every slot, then results go out one
// at a time, each held until the output takes it. The single read port of the track
// memory sets both.
// Reset: valid and updated marks cleared, next id 1, registers to defaults.
// The track memory is not cleared; entries are read only while valid.
module blob_nearest_neighbor_tracker_top #(
    parameter int MAX_TRACKS = 16,
    parameter int COORD_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // mode is tuser; tdata: centroid_x, centroid_y, blob_area, perimeter, has_hole
    input  wire logic [63:0] s_tdata,
    input  wire logic        s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata: track_number, pos_x, pos_y, area_out ; tuser: kind
    output logic [79:0]      m_tdata,
    output logic [1:0]       m_tuser,
    output logic             m_tlast,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [23:0] cfg_data
);
    import bnnt_pkg::*;

    localparam int AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CW = COORD_BITS;
    localparam int CNTW = $clog2(MAX_TRACKS + 1);
    localparam int NOUT = (MAX_TRACKS < MAX_RESULTS) ? MAX_TRACKS : MAX_RESULTS;
    localparam int OW = $clog2(NOUT + 1);
    localparam int IW = (NOUT > 1) ? $clog2(NOUT) : 1;
    localparam int DW = (2 * CW + 1 > 24) ? 2 * CW + 1 : 24;

    // configuration
    logic [11:0] min_per_reg, max_per_reg;
    logic [23:0] match_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_per_reg <= 12'd10;
            max_per_reg <= 12'd60;
            match_reg   <= 24'd12800;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MIN_PER:  min_per_reg <= cfg_data[11:0];
                REG_MAX_PER:  max_per_reg <= cfg_data[11:0];
                REG_MATCH_SQ: match_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    state_t state_reg, state_next;
    logic [MAX_TRACKS-1:0] valid_reg, upd_reg;
    logic [31:0] nid_reg;
    logic [CNTW-1:0] cnt_reg;
    logic rd_ok_reg;
    logic [AW-1:0] rd_slot_reg;
    logic [CW-1:0] bx_reg, by_reg;
    logic [15:0] ba_reg;
    logic found_reg;
    logic [AW-1:0] best_reg;
    logic [31:0] best_id_reg;
    logic [2*CW:0] best_d_reg;
    // ordering list: slots sorted by (id, slot)
    logic [AW-1:0] ord_reg [NOUT];
    logic [31:0]   ordid_reg [NOUT];
    logic [OW-1:0] n_reg, k_reg;

    // nearest track close enough to take the blob
    logic match_hit;
    assign match_hit = found_reg && (DW'(best_d_reg) <= DW'(match_reg));

    // memory
    logic we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0] wid;
    logic [31:0] rid;
    logic [CW-1:0] rx, ry;
    logic [15:0] rarea;
    // a matched track keeps its id, a new one takes the next id
    assign wid = match_hit ? best_id_reg : nid_reg;
    bnnt_track_mem #(.DEPTH(MAX_TRACKS), .AW(AW), .CW(CW)) u_mem (
        .clk(clk), .we(we), .waddr(waddr), .wid(wid), .wx(bx_reg), .wy(by_reg),
        .warea(ba_reg), .raddr(raddr), .rid(rid), .rx(rx), .ry(ry), .rarea(rarea)
    );

    // distance of the slot just read
    logic [CW-1:0] dx, dy;
    logic [2*CW-1:0] dx_sq, dy_sq;
    logic [2*CW:0] sq_dist;
    assign dx = (bx_reg > rx) ? bx_reg - rx : rx - bx_reg;
    assign dy = (by_reg > ry) ? by_reg - ry : ry - by_reg;
    assign dx_sq = {{CW{1'b0}}, dx} * {{CW{1'b0}}, dx};
    assign dy_sq = {{CW{1'b0}}, dy} * {{CW{1'b0}}, dy};
    assign sq_dist = {1'b0, dx_sq} + {1'b0, dy_sq};
    logic better;
    assign better = !found_reg || sq_dist < best_d_reg ||
                    (sq_dist == best_d_reg && rid < best_id_reg);

    // lowest free slot
    logic [AW-1:0] free_slot;
    logic has_free;
    always_comb
    begin
        free_slot = '0;
        has_free = 1'b0;
        for (int i = MAX_TRACKS - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_slot = AW'(i);
                has_free = 1'b1;
            end
        end
    end

    // insertion position of the read slot in the ordered list
    logic [OW-1:0] ins_pos;
    always_comb
    begin
        ins_pos = n_reg;
        for (int j = NOUT - 1; j >= 0; j--)
        begin
            if (OW'(j) < n_reg && rid < ordid_reg[j])
            begin
                ins_pos = OW'(j);
            end
        end
    end

    logic blob_ok;
    assign blob_ok = !s_tdata[60] && s_tdata[59:48] >= min_per_reg &&
                     s_tdata[59:48] <= max_per_reg;
    logic scan_done, cur_last;
    assign scan_done = cnt_reg == CNTW'(MAX_TRACKS);
    logic [AW-1:0] cur_slot;
    assign cur_slot = ord_reg[k_reg[IW-1:0]];
    assign cur_last = k_reg + OW'(1) == n_reg;

    logic out_full_reg;
    logic out_load;
    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = out_full_reg;
    assign out_load = state_reg == ST_EMIT_WAIT && (!out_full_reg || m_tready);

    // control
    always_comb
    begin
        state_next = state_reg;
        we = 1'b0;
        waddr = free_slot;
        raddr = cnt_reg[AW-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser) state_next = ST_SORT;
                    else if (blob_ok) state_next = ST_SCAN;
                end
            end
            ST_SCAN:   if (scan_done && !rd_ok_reg) state_next = ST_COMMIT;
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
                if (match_hit)
                begin
                    we = 1'b1;
                    waddr = best_reg;
                end
                else if (has_free)
                    we = 1'b1;
            end
            ST_SORT:   if (scan_done && !rd_ok_reg) state_next = ST_EMIT;
            ST_EMIT:   state_next = ST_EMIT_WAIT;
            ST_EMIT_WAIT:
            begin
                if (!out_full_reg || m_tready)
                    state_next = (n_reg == '0 || cur_last) ? ST_IDLE : ST_EMIT;
            end
            default:   state_next = ST_IDLE;
        endcase
        // hold the read on the reported slot while the output waits
        if (state_reg == ST_EMIT || state_reg == ST_EMIT_WAIT) raddr = cur_slot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            upd_reg <= '0;
            nid_reg <= 32'd1;
            cnt_reg <= '0;
            rd_ok_reg <= 1'b0;
            found_reg <= 1'b0;
            n_reg <= '0;
            k_reg <= '0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load) out_full_reg <= 1'b1;
            else if (out_full_reg && m_tready) out_full_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    cnt_reg <= '0;
                    rd_ok_reg <= 1'b0;
                    found_reg <= 1'b0;
                    n_reg <= '0;
                    k_reg <= '0;
                end
                ST_SCAN, ST_SORT:
                begin
                    if (!scan_done)
                    begin
                        cnt_reg <= cnt_reg + CNTW'(1);
                        rd_ok_reg <= valid_reg[cnt_reg[AW-1:0]];
                        rd_slot_reg <= cnt_reg[AW-1:0];
                    end
                    else rd_ok_reg <= 1'b0;
                    if (rd_ok_reg && state_reg == ST_SCAN && better)
                    begin
                        found_reg <= 1'b1;
                        best_reg <= rd_slot_reg;
                        best_id_reg <= rid;
                        best_d_reg <= sq_dist;
                    end
                    if (rd_ok_reg && state_reg == ST_SORT && ins_pos < OW'(NOUT))
                    begin
                        for (int j = NOUT - 1; j >= 0; j--)
                        begin
                            if (OW'(j) > ins_pos)
                            begin
                                ord_reg[j] <= ord_reg[(j + NOUT - 1) % NOUT];
                                ordid_reg[j] <= ordid_reg[(j + NOUT - 1) % NOUT];
                            end
                        end
                        ord_reg[ins_pos[IW-1:0]] <= rd_slot_reg;
                        ordid_reg[ins_pos[IW-1:0]] <= rid;
                        if (n_reg < OW'(NOUT)) n_reg <= n_reg + OW'(1);
                    end
                end
                ST_COMMIT:
                begin
                    if (match_hit) upd_reg[best_reg] <= 1'b1;
                    else if (has_free)
                    begin
                        valid_reg[free_slot] <= 1'b1;
                        upd_reg[free_slot] <= 1'b1;
                        nid_reg <= nid_reg + 32'd1;
                    end
                end
                ST_EMIT_WAIT:
                begin
                    if (out_load)
                    begin
                        if (n_reg == '0)
                        begin
                            m_tuser <= KIND_EMPTY;
                            m_tdata <= '0;
                            m_tlast <= 1'b1;
                        end
                        else
                        begin
                            m_tuser <= upd_reg[cur_slot] ? KIND_ALIVE : KIND_REMOVED;
                            m_tdata <= {16'(rarea), 16'(ry), 16'(rx), rid};
                            m_tlast <= cur_last;
                            if (upd_reg[cur_slot]) upd_reg[cur_slot] <= 1'b0;
                            else valid_reg[cur_slot] <= 1'b0;
                            k_reg <= k_reg + OW'(1);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // latch the blob fields
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE)
        begin
            bx_reg <= CW'(s_tdata[15:0]);
            by_reg <= CW'(s_tdata[31:16]);
            ba_reg <= s_tdata[47:32];
        end
    end

    property p_one_work;
        @(posedge clk) disable iff (!rst_n) out_full_reg && !m_tready |=> out_full_reg;
    endproperty
    a_hold: assert property (p_one_work) else $error("result dropped");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COMMIT |=> state_reg == ST_IDLE) else $error("commit stuck");
    a_id: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_COMMIT |=> nid_reg == $past(nid_reg)) else $error("id moved");
endmodule
`default_nettype wire
